// ----- rtl/core/tlfds_pkg.sv -----
// ----------------------------------------------------------------------------
// tlfds_pkg
// Shared types, field widths, command and register codes for the two-level
// filtered dot-product scorer.
// ----------------------------------------------------------------------------
package tlfds_pkg;

    // default sizes for the top level parameters
    localparam int MAX_ROW_LENGTH_DEF = 256;
    localparam int KEY_INDEX_BITS_DEF = 24;

    // field and register widths
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 48;
    localparam int TEST_W      = 50;
    localparam int ROW_LEN_W   = 9;
    localparam int CPP_W       = 13;
    localparam int KEY_CNT_W   = 25;
    localparam int CHILD_IDX_W = 24;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 2;

    // result queue depth
    localparam int OUT_FIFO_DEPTH = 4;

    // saturation limit of the child counter
    localparam logic [CPP_W-1:0] CHILD_MAX = '1;

    // command codes
    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_PARENT = 2'd1;
    localparam logic [1:0] CMD_CHILD  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHILDREN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT  = 2'd3;

    // configuration reset values
    localparam logic signed [SUM_W-1:0] THRESHOLD_RST  = '0;
    localparam logic [ROW_LEN_W-1:0]    ROW_LENGTH_RST = 9'd128;
    localparam logic [CPP_W-1:0]        CHILDREN_RST   = 13'd1;
    localparam logic [KEY_CNT_W-1:0]    KEY_COUNT_RST  = 25'd16777216;

    // input item
    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [ELEM_W-1:0] element;
        logic signed [SUM_W-1:0]  radius;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [CHILD_IDX_W-1:0]  child_index;
        logic signed [SUM_W-1:0] score;
    } out_item_t;

endpackage

// ----- rtl/core/tlfds_ram.sv -----
// ----------------------------------------------------------------------------
// tlfds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlfds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tlfds_out_fifo.sv -----
// ----------------------------------------------------------------------------
// tlfds_out_fifo
// Small result queue that decouples the scoring pipeline from the receiver.
// ----------------------------------------------------------------------------
module tlfds_out_fifo #(
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tlfds_pkg::out_item_t push_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tlfds_pkg::out_item_t m_item,
    output logic [CNT_W-1:0]     count
);

    tlfds_pkg::out_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_item  = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/two_level_filtered_dot_scorer_top.sv -----
// ----------------------------------------------------------------------------
// two_level_filtered_dot_scorer_top
// Streams query, parent and child vector elements and emits scored children.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one vector element per transfer: a query
//   element is stored, parent and child elements are multiplied with the
//   stored query element at the same position and accumulated. cmd 3 is
//   dropped. A finished child row whose parent passed the threshold test,
//   and whose index is within the children and key counts, yields one
//   m_valid/m_ready/m_item transfer with its index and score. Configuration
//   goes through cfg_we/cfg_index/cfg_wdata while no element is in flight;
//   each write lands on the next clock edge. Throughput is one element per
//   cycle while s_ready is high. m_valid goes high once the last child
//   element has passed the query RAM read (with the transfer), the multiply,
//   then the accumulate and filter stage, and the result queue write.
//   s_ready stays high while the four-entry result queue plus the two
//   pipeline stages leave room; when the receiver stalls, the queue fills
//   and s_ready drops until results are taken.
//   Reset (aresetn low, synchronous) restores the register defaults and
//   clears counters, the running sum and the queue. Query RAM contents are
//   not cleared and must be written before use.
// ----------------------------------------------------------------------------
module two_level_filtered_dot_scorer_top #(
    parameter int MAX_ROW_LENGTH = tlfds_pkg::MAX_ROW_LENGTH_DEF,
    parameter int KEY_INDEX_BITS = tlfds_pkg::KEY_INDEX_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tlfds_pkg::in_item_t                s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tlfds_pkg::out_item_t               m_item,
    input  logic                               cfg_we,
    input  logic [tlfds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlfds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int POS_W  = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int LEN_W  = (POS_W + 1 > tlfds_pkg::ROW_LEN_W) ? POS_W + 1
                                                                : tlfds_pkg::ROW_LEN_W;
    localparam int BASE_W = KEY_INDEX_BITS + tlfds_pkg::CPP_W;
    localparam int IDX_W  = (BASE_W + 1 > tlfds_pkg::KEY_CNT_W) ? BASE_W + 1
                                                                : tlfds_pkg::KEY_CNT_W;
    localparam int CNT_W  = $clog2(tlfds_pkg::OUT_FIFO_DEPTH + 1);
    localparam int OCC_W  = CNT_W + 2;
    localparam int SUM_W  = tlfds_pkg::SUM_W;
    localparam int TEST_W = tlfds_pkg::TEST_W;
    localparam int PROD_W = tlfds_pkg::PROD_W;
    localparam int ELEM_W = tlfds_pkg::ELEM_W;
    localparam int CPP_W  = tlfds_pkg::CPP_W;

    // configuration registers
    logic signed [SUM_W-1:0]             threshold_reg;
    logic [tlfds_pkg::ROW_LEN_W-1:0]     row_length_reg;
    logic [CPP_W-1:0]                    cpp_reg;
    logic [tlfds_pkg::KEY_CNT_W-1:0]     key_count_reg;
    logic                                resync_reg;

    // input side
    logic                 accept;
    logic                 take;
    logic [LEN_W-1:0]     eff_len;
    logic                 last_in;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic signed [ELEM_W-1:0] query_rd;

    // stage 1: query read data available
    logic                     s1_valid_reg;
    logic [1:0]               s1_cmd_reg;
    logic signed [ELEM_W-1:0] s1_elem_reg;
    logic signed [SUM_W-1:0]  s1_radius_reg;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] s1_prod;
    logic signed [TEST_W-1:0] s1_tmr;

    // stage 2: accumulate and filter
    logic                     s2_valid_reg;
    logic [1:0]               s2_cmd_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [TEST_W-1:0] s2_tmr_reg;

    // scoring state
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [KEY_INDEX_BITS-1:0] pn_reg, pn_next;
    logic [CPP_W-1:0]          cip_reg, cip_next;
    logic                      passed_reg, passed_next;
    logic [BASE_W-1:0]         base_reg, base_next;

    logic signed [SUM_W-1:0]   sum_acc;
    logic                      pass_test;
    logic [KEY_INDEX_BITS-1:0] pn_m1;
    logic [BASE_W-1:0]         resync_base;
    logic [IDX_W-1:0]          child_idx;
    logic                      child_ok;
    logic                      push;
    tlfds_pkg::out_item_t      push_item;
    logic [CNT_W-1:0]          fifo_count;
    logic [OCC_W-1:0]          occupancy;

    // configuration writes; a branching factor change rebuilds the index base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= tlfds_pkg::THRESHOLD_RST;
            row_length_reg <= tlfds_pkg::ROW_LENGTH_RST;
            cpp_reg        <= tlfds_pkg::CHILDREN_RST;
            key_count_reg  <= tlfds_pkg::KEY_COUNT_RST;
            resync_reg     <= 1'b0;
        end else begin
            resync_reg <= cfg_we && (cfg_index == tlfds_pkg::REG_CHILDREN);
            if (cfg_we) begin
                case (cfg_index)
                    tlfds_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_wdata;
                    tlfds_pkg::REG_ROW_LENGTH: row_length_reg <= cfg_wdata[tlfds_pkg::ROW_LEN_W-1:0];
                    tlfds_pkg::REG_CHILDREN:   cpp_reg        <= cfg_wdata[CPP_W-1:0];
                    tlfds_pkg::REG_KEY_COUNT:  key_count_reg  <= cfg_wdata[tlfds_pkg::KEY_CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // effective row length: zero acts as one, clamp to the RAM depth
    always_comb begin
        if (row_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (LEN_W'(row_length_reg) > LEN_W'(MAX_ROW_LENGTH)) begin
            eff_len = LEN_W'(MAX_ROW_LENGTH);
        end else begin
            eff_len = LEN_W'(row_length_reg);
        end
    end

    // input transfer and element position
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign s_ready   = occupancy < OCC_W'(tlfds_pkg::OUT_FIFO_DEPTH);
    assign accept    = s_valid && s_ready;
    assign take      = accept && (s_item.cmd inside {tlfds_pkg::CMD_QUERY,
                                                      tlfds_pkg::CMD_PARENT,
                                                      tlfds_pkg::CMD_CHILD});
    assign last_in   = (LEN_W'(pos_reg) + LEN_W'(1)) >= eff_len;
    assign pos_next  = !take ? pos_reg : (last_in ? '0 : pos_reg + 1'b1);

    // query element store
    tlfds_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_query_ram (
        .aclk    (aclk),
        .wr_en   (take && (s_item.cmd == tlfds_pkg::CMD_QUERY)),
        .wr_addr (pos_reg),
        .wr_data (s_item.element),
        .rd_addr (pos_reg),
        .rd_data (query_rd)
    );

    // stage 1 and stage 2 valid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        s1_cmd_reg    <= s_item.cmd;
        s1_elem_reg   <= s_item.element;
        s1_radius_reg <= s_item.radius;
        s1_last_reg   <= last_in;
        s2_cmd_reg    <= s1_cmd_reg;
        s2_last_reg   <= s1_last_reg;
        s2_prod_reg   <= s1_prod;
        s2_tmr_reg    <= s1_tmr;
    end

    // product with the stored query element, and threshold minus radius
    assign s1_prod = s1_elem_reg * query_rd;
    assign s1_tmr  = {{(TEST_W - SUM_W){threshold_reg[SUM_W-1]}}, threshold_reg}
                   - {{(TEST_W - SUM_W){s1_radius_reg[SUM_W-1]}}, s1_radius_reg};

    // accumulate, pass test and child filter
    assign sum_acc   = sum_reg + {{(SUM_W - PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
    assign pass_test = $signed({{(TEST_W - SUM_W){sum_acc[SUM_W-1]}}, sum_acc}) > s2_tmr_reg;
    assign child_idx = IDX_W'(base_reg) + IDX_W'(cip_reg);
    assign child_ok  = passed_reg && (pn_reg != '0) && (cip_reg < cpp_reg)
                    && (child_idx < IDX_W'(key_count_reg));
    assign push      = s2_valid_reg && s2_last_reg
                    && (s2_cmd_reg == tlfds_pkg::CMD_CHILD) && child_ok;

    always_comb begin
        push_item             = '0;
        push_item.child_index = child_idx[tlfds_pkg::CHILD_IDX_W-1:0];
        push_item.score       = sum_acc;
    end

    // index base (parent_number - 1) * branching factor, rebuilt after a write
    assign pn_m1       = pn_reg - 1'b1;
    assign resync_base = pn_m1 * cpp_reg;

    // scoring state update
    always_comb begin
        sum_next    = sum_reg;
        pn_next     = pn_reg;
        cip_next    = cip_reg;
        passed_next = passed_reg;
        base_next   = base_reg;
        if (resync_reg) begin
            base_next = (pn_reg == '0) ? '0 : resync_base;
        end
        if (s2_valid_reg) begin
            if (s2_cmd_reg != tlfds_pkg::CMD_QUERY) begin
                sum_next = sum_acc;
            end
            if (s2_last_reg) begin
                sum_next = '0;
                case (s2_cmd_reg)
                    tlfds_pkg::CMD_QUERY: begin
                        pn_next     = '0;
                        cip_next    = '0;
                        passed_next = 1'b0;
                        base_next   = '0;
                    end
                    tlfds_pkg::CMD_PARENT: begin
                        passed_next = pass_test;
                        cip_next    = '0;
                        if (pn_reg != '1) begin
                            pn_next = pn_reg + 1'b1;
                            if (pn_reg != '0) begin
                                base_next = base_reg + BASE_W'(cpp_reg);
                            end
                        end
                    end
                    tlfds_pkg::CMD_CHILD: begin
                        if (cip_reg != tlfds_pkg::CHILD_MAX) begin
                            cip_next = cip_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            pn_reg     <= '0;
            cip_reg    <= '0;
            passed_reg <= 1'b0;
            base_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            pn_reg     <= pn_next;
            cip_reg    <= cip_next;
            passed_reg <= passed_next;
            base_reg   <= base_next;
        end
    end

    // result queue
    tlfds_out_fifo #(
        .DEPTH (tlfds_pkg::OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .count     (fifo_count)
    );

endmodule

// ----- rtl/core/tlfds_checker.sv -----
// ----------------------------------------------------------------------------
// tlfds_checker
// Port-level checks on the scorer: reset, stall hold, latency and flow control.
// ----------------------------------------------------------------------------
module tlfds_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input tlfds_pkg::in_item_t  s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input tlfds_pkg::out_item_t m_item
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // a fresh result follows an accepted child element transfer
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |->
            $past(s_valid && s_ready && (s_item.cmd == tlfds_pkg::CMD_CHILD), 3))
        else $error("result without matching child element");

    // input back-pressure only when results are waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

endmodule

bind two_level_filtered_dot_scorer_top tlfds_checker u_tlfds_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
